// ----- src/mcst_pkg.sv -----
// ----------------------------------------------------------------------------
// mcst_pkg: shared types and constants of the multi-channel soft timer
// Holds the command codes and the beat token that travels along the timer
// cells.
// ----------------------------------------------------------------------------
package mcst_pkg;

  localparam int unsigned NUM_TIMERS_DEF = 8;
  localparam int unsigned MASK_W         = 8;
  localparam int unsigned SLOT_W         = 3;
  localparam int unsigned CNT_W          = 32;
  localparam int unsigned UNIT_W         = 8;

  typedef enum logic [2:0] {
    MODE_TICK       = 3'd0,
    MODE_ALLOC      = 3'd1,
    MODE_ACTIVATE   = 3'd2,
    MODE_DEACTIVATE = 3'd3,
    MODE_UPD_PERIOD = 3'd4,
    MODE_UPD_SHOT   = 3'd5,
    MODE_CLEAR      = 3'd6
  } mode_t;

  // One command beat on its way through the cells, with the result built so far.
  typedef struct packed {
    logic [2:0]        mode;
    logic [SLOT_W-1:0] id;
    logic [CNT_W-1:0]  target;
    logic              shot;
    logic [MASK_W-1:0] fired;
    logic [MASK_W-1:0] flags;
    logic              alloc_ok;
    logic [SLOT_W-1:0] alloc_slot;
  } tok_t;

endpackage

// ----- src/mcst_cell.sv -----
// ----------------------------------------------------------------------------
// mcst_cell: one timer slot of the chain
// Holds the state of a single timer, applies the passing command beat to it
// and hands the beat, with its own contribution, to the next cell.
// ----------------------------------------------------------------------------
module mcst_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          tok_valid_i,
  input  mcst_pkg::tok_t tok_i,
  output logic          tok_valid_o,
  output mcst_pkg::tok_t tok_o
);

  logic                       active_r, active_nxt;
  logic                       alloc_r, alloc_nxt;
  logic                       shot_r, shot_nxt;
  logic                       flag_r, flag_nxt;
  logic [mcst_pkg::CNT_W-1:0] target_r, target_nxt;
  logic [mcst_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [mcst_pkg::CNT_W-1:0] cnt_inc;
  logic                       id_hit;
  logic                       valid_r;
  mcst_pkg::tok_t             tok_r, tok_nxt;

  assign cnt_inc = cnt_r + mcst_pkg::CNT_W'(1);
  // Slot numbers above what the id field can name are never addressed.
  assign id_hit  = (IDX < 8) && (tok_i.id == mcst_pkg::SLOT_W'(IDX));

  always_comb begin
    active_nxt = active_r;
    alloc_nxt  = alloc_r;
    shot_nxt   = shot_r;
    flag_nxt   = flag_r;
    target_nxt = target_r;
    cnt_nxt    = cnt_r;
    tok_nxt    = tok_i;
    if (tok_valid_i) begin
      case (mcst_pkg::mode_t'(tok_i.mode))
        mcst_pkg::MODE_TICK: begin
          if (active_r) begin
            cnt_nxt = cnt_inc;
            if ((target_r != '0) && (cnt_inc == target_r)) begin
              cnt_nxt  = '0;
              flag_nxt = 1'b1;
              if (shot_r) begin
                active_nxt = 1'b0;
              end
              if (IDX < 8) begin
                tok_nxt.fired[mcst_pkg::SLOT_W'(IDX)] = 1'b1;
              end
            end
          end
        end
        mcst_pkg::MODE_ALLOC: begin
          // The first free cell along the chain takes the allocation.
          if (!tok_i.alloc_ok && !alloc_r) begin
            target_nxt         = tok_i.target;
            shot_nxt           = tok_i.shot;
            alloc_nxt          = 1'b1;
            tok_nxt.alloc_ok   = 1'b1;
            tok_nxt.alloc_slot = mcst_pkg::SLOT_W'(IDX);
          end
        end
        mcst_pkg::MODE_ACTIVATE: begin
          if (id_hit) begin
            cnt_nxt    = '0;
            active_nxt = 1'b1;
          end
        end
        mcst_pkg::MODE_DEACTIVATE: begin
          if (id_hit) begin
            active_nxt = 1'b0;
            cnt_nxt    = '0;
            flag_nxt   = 1'b0;
          end
        end
        mcst_pkg::MODE_UPD_PERIOD: begin
          if (id_hit) begin
            cnt_nxt    = '0;
            target_nxt = tok_i.target;
          end
        end
        mcst_pkg::MODE_UPD_SHOT: begin
          if (id_hit) begin
            shot_nxt = tok_i.shot;
            cnt_nxt  = '0;
          end
        end
        mcst_pkg::MODE_CLEAR: begin
          if (id_hit) begin
            active_nxt = 1'b0;
            alloc_nxt  = 1'b0;
            shot_nxt   = 1'b0;
            flag_nxt   = 1'b0;
            target_nxt = '0;
            cnt_nxt    = '0;
          end
        end
        default: begin
        end
      endcase
      if (IDX < 8) begin
        tok_nxt.flags[mcst_pkg::SLOT_W'(IDX)] = flag_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      alloc_r  <= 1'b0;
      shot_r   <= 1'b0;
      flag_r   <= 1'b0;
      target_r <= '0;
      cnt_r    <= '0;
      valid_r  <= 1'b0;
    end else begin
      active_r <= active_nxt;
      alloc_r  <= alloc_nxt;
      shot_r   <= shot_nxt;
      flag_r   <= flag_nxt;
      target_r <= target_nxt;
      cnt_r    <= cnt_nxt;
      valid_r  <= tok_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  assign tok_valid_o = valid_r;
  assign tok_o       = tok_r;

endmodule

// ----- src/multi_channel_soft_timer.sv -----
// ----------------------------------------------------------------------------
// multi_channel_soft_timer: bank of periodic and one-shot software timers
// A row of timer cells, one per slot. Each command beat walks the row one
// cell per cycle and collects fired bits, flags and the allocation result.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake         Payload
//   in_      input      in_valid/in_stall  mode, timer id, period, unit, one-shot
//   out_     output     out_valid/out_stall fired mask, flag mask, alloc result
//
// One beat is in flight at a time. From acceptance, a beat passes the entry
// register, which holds the period times unit product, one register per
// timer cell and the output register before its result is valid. The input
// stays stalled from acceptance until the result has been taken. Reset is
// synchronous and active low; it frees every slot. A stalled result holds in
// the output register and keeps the input stalled.
// ----------------------------------------------------------------------------
module multi_channel_soft_timer #(
  parameter int unsigned NUM_TIMERS = mcst_pkg::NUM_TIMERS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  in_mode,
  input  logic [mcst_pkg::SLOT_W-1:0] in_timer_id,
  input  logic [mcst_pkg::CNT_W-1:0]  in_period_value,
  input  logic [mcst_pkg::UNIT_W-1:0] in_unit_multiplier,
  input  logic                        in_one_shot_bit,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mcst_pkg::MASK_W-1:0] out_fired_mask,
  output logic [mcst_pkg::MASK_W-1:0] out_flag_mask,
  output logic                        out_alloc_ok,
  output logic [mcst_pkg::SLOT_W-1:0] out_alloc_slot
);

  localparam int unsigned PROD_W = mcst_pkg::CNT_W + mcst_pkg::UNIT_W;

  // Busy covers the whole life of a beat, from acceptance until its result
  // has been taken, so the cells never see two commands at once.
  logic busy_r, busy_nxt;
  logic in_acc;
  logic out_acc;

  // Entry stage: the product is formed once here and carried as the target.
  logic                       e_valid_r;
  mcst_pkg::tok_t             e_tok_r, e_tok_nxt;
  logic [PROD_W-1:0]          prod;

  // Beat links between the cells; link 0 is the entry stage.
  logic           [NUM_TIMERS:0] link_valid;
  mcst_pkg::tok_t                link_tok [NUM_TIMERS+1];

  logic                        out_valid_r;
  logic [mcst_pkg::MASK_W-1:0] out_fired_r;
  logic [mcst_pkg::MASK_W-1:0] out_flags_r;
  logic                        out_ok_r;
  logic [mcst_pkg::SLOT_W-1:0] out_slot_r;

  assign in_stall = busy_r;
  assign in_acc   = in_valid && !busy_r;
  assign out_acc  = out_valid_r && !out_stall;

  always_comb begin
    busy_nxt = busy_r;
    if (in_acc) begin
      busy_nxt = 1'b1;
    end else if (out_acc) begin
      busy_nxt = 1'b0;
    end
  end

  // The stored target is the product truncated to the counter width, exactly
  // what the tick compare needs.
  assign prod = PROD_W'(in_period_value) * PROD_W'(in_unit_multiplier);

  always_comb begin
    e_tok_nxt            = '0;
    e_tok_nxt.mode       = in_mode;
    e_tok_nxt.id         = in_timer_id;
    e_tok_nxt.target     = prod[mcst_pkg::CNT_W-1:0];
    e_tok_nxt.shot       = in_one_shot_bit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      e_valid_r <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      e_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      e_tok_r <= e_tok_nxt;
    end
  end

  assign link_valid[0] = e_valid_r;
  assign link_tok[0]   = e_tok_r;

  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
    mcst_cell #(
      .IDX(g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .tok_valid_i(link_valid[g]),
      .tok_i      (link_tok[g]),
      .tok_valid_o(link_valid[g+1]),
      .tok_o      (link_tok[g+1])
    );
  end

  // Output register: loaded when the beat leaves the last cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (link_valid[NUM_TIMERS]) begin
      out_valid_r <= 1'b1;
    end else if (out_acc) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (link_valid[NUM_TIMERS]) begin
      out_fired_r <= link_tok[NUM_TIMERS].fired;
      out_flags_r <= link_tok[NUM_TIMERS].flags;
      out_ok_r    <= link_tok[NUM_TIMERS].alloc_ok;
      out_slot_r  <= link_tok[NUM_TIMERS].alloc_slot;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_fired_mask = out_fired_r;
  assign out_flag_mask  = out_flags_r;
  assign out_alloc_ok   = out_ok_r;
  assign out_alloc_slot = out_slot_r;

  // Assertions ---------------------------------------------------------------

  // At most one beat is anywhere in the row or the output register.
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({out_valid_r, link_valid}))
    else $error("more than one beat in flight");

  // With the block idle, no stage holds a beat.
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> ({out_valid_r, link_valid} == '0))
    else $error("beat present while idle");

  // An accepted beat enters the entry stage on the next cycle.
  a_entry: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> e_valid_r)
    else $error("accepted beat lost at entry");

  // A failed or absent allocation reports slot zero.
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> (out_slot_r == '0))
    else $error("slot reported without allocation");

endmodule

// ----- tb/multi_channel_soft_timer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_soft_timer_tb: self-checking testbench for the soft timer bank
// Drives command beats into the timer bank and checks every result beat
// against an in-house model of the bank. A directed opening covers field
// extremes, every command and the corner cases. A long random run follows,
// built mostly from small timer periods so that timers really fire. Both
// channels pause at random, with stretches where neither side pauses.
// ----------------------------------------------------------------------------
module multi_channel_soft_timer_tb;

  localparam int unsigned TIMERS = mcst_pkg::NUM_TIMERS_DEF;

  // Command code 7 has no meaning and must leave the bank untouched.
  localparam logic [2:0] MODE_UNUSED = 3'd7;

  localparam int unsigned RANDOM_CMDS  = 600;
  // Commands before the pacing is drawn again, so that some stretches run flat out.
  localparam int unsigned PACE_SPAN    = 50;
  localparam int unsigned MAX_PAUSE    = 16;
  // Drain time after the last result, scaled to the time that one beat needs.
  localparam int unsigned DRAIN_CYCLES = 3 * (TIMERS + 3);
  // Limit on a quiet stretch before the watchdog calls the run hung.
  localparam int unsigned QUIET_LIMIT  = 1000;

  // One result beat, laid out field by field as the output ports carry it.
  typedef struct packed {
    logic [mcst_pkg::MASK_W-1:0] fired;
    logic [mcst_pkg::MASK_W-1:0] flags;
    logic                        ok;
    logic [mcst_pkg::SLOT_W-1:0] slot;
  } timer_result_t;

  // Model of the timer bank: it holds its own copy of every slot, works out
  // the result beat of each accepted command and keeps those beats in order
  // until the bank delivers them.
  class timer_bank_model;
    bit                          active[TIMERS];
    bit                          allocated[TIMERS];
    bit                          fire_once[TIMERS];
    bit                          flag[TIMERS];
    bit [mcst_pkg::CNT_W-1:0]    period[TIMERS];
    bit [mcst_pkg::UNIT_W-1:0]   unit[TIMERS];
    bit [mcst_pkg::CNT_W-1:0]    ticks[TIMERS];
    timer_result_t               expected_results[$];
    int unsigned                 errors;

    function new();
      errors = 0;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function void free_slot(int unsigned s);
      active[s]    = 1'b0;
      allocated[s] = 1'b0;
      fire_once[s] = 1'b0;
      flag[s]      = 1'b0;
      period[s]    = '0;
      unit[s]      = '0;
      ticks[s]     = '0;
    endfunction

    function void note_command(logic [2:0] mode, logic [mcst_pkg::SLOT_W-1:0] id,
                               logic [mcst_pkg::CNT_W-1:0] per,
                               logic [mcst_pkg::UNIT_W-1:0] unt, logic shot);
      timer_result_t            res;
      bit [mcst_pkg::CNT_W-1:0] goal;
      bit                       found;
      int unsigned              i;
      res   = '0;
      found = 1'b0;
      case (mode)
        mcst_pkg::MODE_TICK: begin
          for (i = 0; i < TIMERS; i++) begin
            if (active[i]) begin
              ticks[i] = ticks[i] + 1;
              // The product is cut to 32 bits; a zero product never fires.
              goal = period[i] * unit[i];
              if (goal != 0 && ticks[i] == goal) begin
                if (fire_once[i]) active[i] = 1'b0;
                ticks[i] = '0;
                flag[i]  = 1'b1;
                if (i < mcst_pkg::MASK_W) res.fired[i] = 1'b1;
              end
            end
          end
        end
        mcst_pkg::MODE_ALLOC: begin
          for (i = 0; i < TIMERS; i++) begin
            if (!found && !allocated[i]) begin
              found        = 1'b1;
              period[i]    = per;
              unit[i]      = unt;
              fire_once[i] = shot;
              allocated[i] = 1'b1;
              res.ok       = 1'b1;
              res.slot     = i[mcst_pkg::SLOT_W-1:0];
            end
          end
        end
        default: begin
          if (id < TIMERS) begin
            case (mode)
              mcst_pkg::MODE_ACTIVATE: begin
                ticks[id]  = '0;
                active[id] = 1'b1;
              end
              mcst_pkg::MODE_DEACTIVATE: begin
                active[id] = 1'b0;
                ticks[id]  = '0;
                flag[id]   = 1'b0;
              end
              mcst_pkg::MODE_UPD_PERIOD: begin
                ticks[id]  = '0;
                period[id] = per;
                unit[id]   = unt;
              end
              mcst_pkg::MODE_UPD_SHOT: begin
                fire_once[id] = shot;
                ticks[id]     = '0;
              end
              mcst_pkg::MODE_CLEAR: free_slot(id);
              default: ;
            endcase
          end
        end
      endcase
      for (i = 0; i < TIMERS && i < mcst_pkg::MASK_W; i++) res.flags[i] = flag[i];
      expected_results.push_back(res);
    endfunction

    function void check_result(timer_result_t got);
      timer_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with no command waiting: fired %h flags %h ok %b slot %0d",
                 $time, got.fired, got.flags, got.ok, got.slot);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got.fired !== want.fired) begin
        $display("%0t: fired_mask mismatch: expected %h, actual %h",
                 $time, want.fired, got.fired);
        errors++;
      end
      if (got.flags !== want.flags) begin
        $display("%0t: flag_mask mismatch: expected %h, actual %h",
                 $time, want.flags, got.flags);
        errors++;
      end
      if (got.ok !== want.ok) begin
        $display("%0t: alloc_ok mismatch: expected %b, actual %b", $time, want.ok, got.ok);
        errors++;
      end
      if (got.slot !== want.slot) begin
        $display("%0t: alloc_slot mismatch: expected %0d, actual %0d",
                 $time, want.slot, got.slot);
        errors++;
      end
    endfunction
  endclass

  // Every input of the bank starts from a known value at time zero.
  logic                        clk                = 1'b0;
  logic                        rst_n              = 1'b0;
  logic                        in_valid           = 1'b0;
  logic                        in_stall;
  logic [2:0]                  in_mode            = '0;
  logic [mcst_pkg::SLOT_W-1:0] in_timer_id        = '0;
  logic [mcst_pkg::CNT_W-1:0]  in_period_value    = '0;
  logic [mcst_pkg::UNIT_W-1:0] in_unit_multiplier = '0;
  logic                        in_one_shot_bit    = 1'b0;
  logic                        out_valid;
  logic                        out_stall          = 1'b0;
  logic [mcst_pkg::MASK_W-1:0] out_fired_mask;
  logic [mcst_pkg::MASK_W-1:0] out_flag_mask;
  logic                        out_alloc_ok;
  logic [mcst_pkg::SLOT_W-1:0] out_alloc_slot;

  timer_bank_model timer_model;

  // When clear, neither side pauses between beats.
  bit pace_on = 1'b1;

  int unsigned quiet_cycles = 0;

  multi_channel_soft_timer #(
    .NUM_TIMERS(TIMERS)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_timer_id        (in_timer_id),
    .in_period_value    (in_period_value),
    .in_unit_multiplier (in_unit_multiplier),
    .in_one_shot_bit    (in_one_shot_bit),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_fired_mask     (out_fired_mask),
    .out_flag_mask      (out_flag_mask),
    .out_alloc_ok       (out_alloc_ok),
    .out_alloc_slot     (out_alloc_slot)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offers one command beat after a random pause and returns at the edge
  // that accepts it. The valid line is only lowered when a pause follows, so
  // back-to-back beats never see valid dropped and raised in one time step.
  task automatic send_command(input logic [2:0] mode,
                              input logic [mcst_pkg::SLOT_W-1:0] id,
                              input logic [mcst_pkg::CNT_W-1:0] per,
                              input logic [mcst_pkg::UNIT_W-1:0] unt, input logic shot);
    int unsigned gap;
    gap = pace_on ? $urandom_range(0, MAX_PAUSE) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_mode            <= mode;
    in_timer_id        <= id;
    in_period_value    <= per;
    in_unit_multiplier <= unt;
    in_one_shot_bit    <= shot;
    // Values read right after the edge are those the bank sampled at it.
    do @(posedge clk); while (in_stall);
    timer_model.note_command(mode, id, per, unt, shot);
  endtask

  // Random command, weighted toward ticks and slot set-up so that timers
  // get allocated, started and run down to their firing point. Most periods
  // are tiny; the rest hit full-width values, wrapped products and zeros.
  task automatic random_command();
    int unsigned                 pick;
    logic [2:0]                  mode;
    logic [mcst_pkg::CNT_W-1:0]  per;
    logic [mcst_pkg::UNIT_W-1:0] unt;
    pick = $urandom_range(0, 99);
    if (pick < 48) mode = mcst_pkg::MODE_TICK;
    else if (pick < 58) mode = mcst_pkg::MODE_ALLOC;
    else if (pick < 70) mode = mcst_pkg::MODE_ACTIVATE;
    else if (pick < 75) mode = mcst_pkg::MODE_DEACTIVATE;
    else if (pick < 83) mode = mcst_pkg::MODE_UPD_PERIOD;
    else if (pick < 90) mode = mcst_pkg::MODE_UPD_SHOT;
    else if (pick < 98) mode = mcst_pkg::MODE_CLEAR;
    else mode = MODE_UNUSED;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      per = $urandom_range(1, 4);
      unt = mcst_pkg::UNIT_W'($urandom_range(1, 3));
    end else if (pick < 8) begin
      per = $urandom();
      unt = mcst_pkg::UNIT_W'($urandom_range(0, 255));
    end else if (pick < 9) begin
      // Top bit set and a unit of two: the product wraps to a small value.
      per = 32'h8000_0000 | $urandom_range(0, 3);
      unt = 8'd2;
    end else begin
      per = $urandom_range(0, 1);
      unt = mcst_pkg::UNIT_W'($urandom_range(0, 1));
    end
    send_command(mode, mcst_pkg::SLOT_W'($urandom_range(0, TIMERS - 1)), per, unt,
                 1'($urandom_range(0, 1)));
  endtask

  // Result side: pauses a random number of cycles before each beat, then
  // takes the next beat and hands it to the model for checking.
  initial begin
    int unsigned   hold;
    timer_result_t got;
    wait (rst_n === 1'b1);
    forever begin
      hold = pace_on ? $urandom_range(0, MAX_PAUSE) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      got = {out_fired_mask, out_flag_mask, out_alloc_ok, out_alloc_slot};
      timer_model.check_result(got);
    end
  end

  // Watchdog: a run that moves no beat on either channel for too long is hung.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    timer_model = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A tick on an empty bank fires nothing.
    send_command(mcst_pkg::MODE_TICK, 3'd0, 32'd0, 8'd0, 1'b0);
    // Slot 0 fires on every tick; slot 1 has the largest period and unit;
    // slot 2 has a product that wraps to two and fires once; slot 3 has a
    // product that wraps to zero and so never fires.
    send_command(mcst_pkg::MODE_ALLOC, 3'd0, 32'd1, 8'd1, 1'b0);
    send_command(mcst_pkg::MODE_ALLOC, 3'd0, 32'hFFFF_FFFF, 8'hFF, 1'b1);
    send_command(mcst_pkg::MODE_ALLOC, 3'd0, 32'h8000_0001, 8'd2, 1'b1);
    send_command(mcst_pkg::MODE_ALLOC, 3'd0, 32'h8000_0000, 8'd2, 1'b0);
    for (n = 0; n < 4; n++) begin
      send_command(mcst_pkg::MODE_ACTIVATE, n[mcst_pkg::SLOT_W-1:0], '0, '0, 1'b0);
    end
    send_command(mcst_pkg::MODE_TICK, 3'd0, 32'd0, 8'd0, 1'b0);
    send_command(mcst_pkg::MODE_TICK, 3'd7, 32'hFFFF_FFFF, 8'hFF, 1'b1);
    // Turning slot 0 into a one-shot stops it after its next firing.
    send_command(mcst_pkg::MODE_UPD_SHOT, 3'd0, 32'd0, 8'd0, 1'b1);
    send_command(mcst_pkg::MODE_TICK, 3'd0, 32'd0, 8'd0, 1'b0);
    // Stopping a slot clears its flag as well.
    send_command(mcst_pkg::MODE_DEACTIVATE, 3'd2, 32'd0, 8'd0, 1'b0);
    // Commands on a slot that was never allocated still take effect.
    send_command(mcst_pkg::MODE_UPD_PERIOD, 3'd7, 32'd2, 8'd1, 1'b0);
    send_command(mcst_pkg::MODE_ACTIVATE, 3'd7, 32'd0, 8'd0, 1'b0);
    send_command(mcst_pkg::MODE_TICK, 3'd0, 32'd0, 8'd0, 1'b0);
    send_command(mcst_pkg::MODE_TICK, 3'd0, 32'd0, 8'd0, 1'b0);
    send_command(MODE_UNUSED, 3'd5, 32'hFFFF_FFFF, 8'hFF, 1'b1);
    // Fill the remaining slots; the last request finds no free slot.
    for (n = 0; n < 5; n++) send_command(mcst_pkg::MODE_ALLOC, 3'd0, 32'd3, 8'd1, n[0]);
    send_command(mcst_pkg::MODE_CLEAR, 3'd7, 32'd0, 8'd0, 1'b0);

    for (n = 0; n < RANDOM_CMDS; n++) begin
      if (n % PACE_SPAN == 0) pace_on = ($urandom_range(0, 3) != 0);
      random_command();
    end
    in_valid <= 1'b0;

    // Wait for the last result, then give a stray extra beat time to show up.
    while (timer_model.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (timer_model.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
